// ===== rtl/sss_pkg.sv =====
// Shared types and constants of the sensor scan sequencer.
package sss_pkg;

    // Number of multiplexed line sensors on the line converter channel
    localparam int LINE_SENSORS = 11;
    // Sample store: line samples first, then distance 0 and distance 1
    localparam int STORE_DEPTH  = LINE_SENSORS + 2;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 8;
    localparam int FLAG_LINES   = 6;
    localparam int FLAG_BASE    = 5;

    // APB register map
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam logic [0:0] REG_LINE_THR = 1'b0;
    localparam logic [0:0] REG_DIST_THR = 1'b1;
    localparam logic [DATA_W-1:0] LINE_THR_RESET = 8'h80;
    localparam logic [DATA_W-1:0] DIST_THR_RESET = 8'h20;

    // Converter channels
    localparam logic [2:0] CH_LINE  = 3'd7;
    localparam logic [2:0] CH_DIST0 = 3'd4;
    localparam logic [2:0] CH_DIST1 = 3'd5;

    // Host request codes (low nibble, high nibble must be zero)
    localparam logic [3:0] RQ_LINES = 4'h0;
    localparam logic [3:0] RQ_DIST0 = 4'h2;
    localparam logic [3:0] RQ_DIST1 = 4'h3;
    localparam logic [3:0] RQ_ALL   = 4'hF;

    typedef enum logic [1:0] {
        MODE_START    = 2'd0,
        MODE_SAMPLE   = 2'd1,
        MODE_REQUEST  = 2'd2,
        MODE_RESERVED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CONVERT  = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_READBACK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_READ
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_SAMPLE,
        CMD_RB_FIRST,
        CMD_RB_NEXT
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scanning;
        logic rb_valid;
        logic out_last;
    } t_dp_status;

endpackage

// ===== rtl/sensor_scan_sequencer.sv =====
// Top level of the sensor scan sequencer: APB registers, controller and datapath.
//
// Input channel (i_in_valid / o_in_ready): one transaction carries a mode, a
// converter sample and a host request byte. Start (mode 0) begins a scan of the
// line sensors, then distance channels 4 and 5; each sample (mode 1) during a
// scan is stored and answered with the next channel, the last one with scan
// complete and the flag byte. A host request (mode 2) reads stored bytes back.
// Output channel (o_out_valid / i_out_ready): during a readback, one result
// transaction per cycle while the receiver takes them; o_last marks the final
// one of an input. The result is registered and valid in the cycle after the
// input is taken. The controller handles one input at a time; inputs with no
// result leave it idle and ready for the next input.
// A receiver stall holds the result register and o_in_ready stays low until
// all results of the current input are taken.
// Reset (i_rst_n low, synchronous) clears the sample store, ends any scan and
// loads the thresholds with 128 (line) and 32 (distance).
// Registers: line threshold at 0x0, distance threshold at 0x4.
module sensor_scan_sequencer import sss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [DATA_W-1:0]  i_sample,
    input  logic [7:0]         i_request,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_out_kind,
    output logic [2:0]         o_adc_channel,
    output logic [ADDR_W-1:0]  o_line_address,
    output logic               o_settle_wait,
    output logic [7:0]         o_flag_byte,
    output logic [DATA_W-1:0]  o_data_byte,
    output logic               o_last,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [DATA_W-1:0] r_line_thr;
    logic [DATA_W-1:0] r_dist_thr;
    logic              cfg_wr;
    t_dp_status        status;
    t_cmd              cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr <= LINE_THR_RESET;
            r_dist_thr <= DIST_THR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LINE_THR) begin
                r_line_thr <= pwdata[DATA_W-1:0];
            end
            if (paddr[2] == REG_DIST_THR) begin
                r_dist_thr <= pwdata[DATA_W-1:0];
            end
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_LINE_THR: prdata = {{(PDATA_W-DATA_W){1'b0}}, r_line_thr};
            REG_DIST_THR: prdata = {{(PDATA_W-DATA_W){1'b0}}, r_dist_thr};
            default:      prdata = '0;
        endcase
    end

    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sss_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample       (i_sample),
        .i_request      (i_request),
        .i_line_thr     (r_line_thr),
        .i_dist_thr     (r_dist_thr),
        .o_status       (status),
        .o_out_kind     (o_out_kind),
        .o_adc_channel  (o_adc_channel),
        .o_line_address (o_line_address),
        .o_settle_wait  (o_settle_wait),
        .o_flag_byte    (o_flag_byte),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/sss_ctrl.sv =====
// Controller state machine of the sensor scan sequencer.
module sss_ctrl import sss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    t_mode  mode;
    logic   in_acc;

    assign mode   = t_mode'(i_mode);
    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (mode)
                        MODE_START:   n_state = ST_SINGLE;
                        MODE_SAMPLE:  n_state = i_status.scanning ? ST_SINGLE : ST_IDLE;
                        MODE_REQUEST: n_state = i_status.rb_valid ? ST_READ : ST_IDLE;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SINGLE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (i_out_ready && i_status.out_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    unique case (mode)
                        MODE_START:   o_cmd = CMD_START;
                        MODE_SAMPLE:  o_cmd = i_status.scanning ? CMD_SAMPLE : CMD_NONE;
                        MODE_REQUEST: o_cmd = i_status.rb_valid ? CMD_RB_FIRST : CMD_NONE;
                        default:      o_cmd = CMD_NONE;
                    endcase
                end
            end
            ST_SINGLE: begin
                o_out_valid = 1'b1;
            end
            ST_READ: begin
                o_out_valid = 1'b1;
                if (i_out_ready && !i_status.out_last) begin
                    o_cmd = CMD_RB_NEXT;
                end
            end
            default: begin
                o_cmd = CMD_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/sss_datapath.sv =====
// Datapath of the sensor scan sequencer: sample store, scan step and result register.
module sss_datapath import sss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_sample,
    input  logic [7:0]        i_request,
    input  logic [DATA_W-1:0] i_line_thr,
    input  logic [DATA_W-1:0] i_dist_thr,
    output t_dp_status        o_status,
    output logic [1:0]        o_out_kind,
    output logic [2:0]        o_adc_channel,
    output logic [ADDR_W-1:0] o_line_address,
    output logic              o_settle_wait,
    output logic [7:0]        o_flag_byte,
    output logic [DATA_W-1:0] o_data_byte,
    output logic              o_last
);

    localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(LINE_SENSORS - 1);
    localparam logic [IDX_W-1:0] DIST0_IDX = IDX_W'(LINE_SENSORS);
    localparam logic [IDX_W-1:0] DIST1_IDX = IDX_W'(LINE_SENSORS + 1);

    logic [DATA_W-1:0] r_store [STORE_DEPTH];
    logic              r_scanning, n_scanning;
    logic [IDX_W-1:0]  r_step, n_step;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_end, n_end;
    logic              store_we;

    logic [1:0]        r_kind, n_kind;
    logic [2:0]        r_chan, n_chan;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_settle, n_settle;
    logic [7:0]        r_flags, n_flags;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;

    logic [IDX_W-1:0]  step_inc;
    logic [IDX_W-1:0]  idx_inc;
    logic [7:0]        flags;
    logic              rb_valid;
    logic [IDX_W-1:0]  rb_start, rb_end;

    assign step_inc = r_step + IDX_W'(1);
    assign idx_inc  = r_idx + IDX_W'(1);

    // Threshold flags; the final distance sample is taken straight from the input
    always_comb begin
        flags = '0;
        for (int i = 0; i < FLAG_LINES; i++) begin
            if (FLAG_BASE + i < LINE_SENSORS) begin
                flags[i] = r_store[FLAG_BASE + i] > i_line_thr;
            end
        end
        flags[6] = r_store[LINE_SENSORS] > i_dist_thr;
        flags[7] = i_sample > i_dist_thr;
    end

    // Readback request decode: first and last store entry
    always_comb begin
        rb_valid = 1'b0;
        rb_start = '0;
        rb_end   = '0;
        if (i_request[7:4] == 4'h0) begin
            unique case (i_request[3:0])
                RQ_LINES: begin
                    rb_valid = 1'b1;
                    rb_start = '0;
                    rb_end   = LAST_LINE;
                end
                RQ_DIST0: begin
                    rb_valid = 1'b1;
                    rb_start = DIST0_IDX;
                    rb_end   = DIST0_IDX;
                end
                RQ_DIST1: begin
                    rb_valid = 1'b1;
                    rb_start = DIST1_IDX;
                    rb_end   = DIST1_IDX;
                end
                RQ_ALL: begin
                    rb_valid = 1'b1;
                    rb_start = '0;
                    rb_end   = DIST1_IDX;
                end
                default: begin
                    rb_valid = 1'b0;
                end
            endcase
        end
    end

    // Next values for scan state and result register
    always_comb begin
        n_scanning = r_scanning;
        n_step     = r_step;
        n_idx      = r_idx;
        n_end      = r_end;
        store_we   = 1'b0;
        n_kind     = r_kind;
        n_chan     = r_chan;
        n_addr     = r_addr;
        n_settle   = r_settle;
        n_flags    = r_flags;
        n_data     = r_data;
        n_last     = r_last;
        case (i_cmd)
            CMD_START: begin
                n_scanning = 1'b1;
                n_step     = '0;
                n_kind     = KIND_CONVERT;
                n_chan     = CH_LINE;
                n_addr     = '0;
                n_settle   = 1'b1;
                n_flags    = '0;
                n_data     = '0;
                n_last     = 1'b1;
            end
            CMD_SAMPLE: begin
                store_we = 1'b1;
                n_kind   = KIND_CONVERT;
                n_addr   = '0;
                n_settle = 1'b0;
                n_flags  = '0;
                n_data   = '0;
                n_last   = 1'b1;
                if (r_step < LAST_LINE) begin
                    n_step   = step_inc;
                    n_chan   = CH_LINE;
                    n_addr   = step_inc[ADDR_W-1:0];
                    n_settle = 1'b1;
                end else if (r_step == LAST_LINE) begin
                    n_step = DIST0_IDX;
                    n_chan = CH_DIST0;
                end else if (r_step == DIST0_IDX) begin
                    n_step = DIST1_IDX;
                    n_chan = CH_DIST1;
                end else begin
                    // final distance sample: scan complete
                    n_scanning = 1'b0;
                    n_step     = '0;
                    n_kind     = KIND_DONE;
                    n_chan     = '0;
                    n_flags    = flags;
                end
            end
            CMD_RB_FIRST: begin
                n_idx    = rb_start;
                n_end    = rb_end;
                n_kind   = KIND_READBACK;
                n_chan   = '0;
                n_addr   = '0;
                n_settle = 1'b0;
                n_flags  = '0;
                n_data   = r_store[rb_start];
                n_last   = (rb_start == rb_end);
            end
            CMD_RB_NEXT: begin
                n_idx  = idx_inc;
                n_data = r_store[idx_inc];
                n_last = (idx_inc == r_end);
            end
            default: begin
                n_scanning = r_scanning;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_step     <= '0;
        end else begin
            r_scanning <= n_scanning;
            r_step     <= n_step;
        end
    end

    // Sample store, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (store_we) begin
            r_store[r_step] <= i_sample;
        end
    end

    // Result register and readback pointer
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_end    <= n_end;
        r_kind   <= n_kind;
        r_chan   <= n_chan;
        r_addr   <= n_addr;
        r_settle <= n_settle;
        r_flags  <= n_flags;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_status.scanning = r_scanning;
    assign o_status.rb_valid = rb_valid;
    assign o_status.out_last = r_last;

    assign o_out_kind     = r_kind;
    assign o_adc_channel  = r_chan;
    assign o_line_address = r_addr;
    assign o_settle_wait  = r_settle;
    assign o_flag_byte    = r_flags;
    assign o_data_byte    = r_data;
    assign o_last         = r_last;

endmodule

// ===== sim/sss_checker.sv =====
// Checker for the sensor scan sequencer: predicts results and compares them.
`timescale 1ns / 100ps

module sss_checker import sss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [DATA_W-1:0]  i_sample,
    input  logic [7:0]         i_request,
    // result channel
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_out_kind,
    input  logic [2:0]         i_adc_channel,
    input  logic [ADDR_W-1:0]  i_line_address,
    input  logic               i_settle_wait,
    input  logic [7:0]         i_flag_byte,
    input  logic [DATA_W-1:0]  i_data_byte,
    input  logic               i_last,
    // configuration port
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    // status to the testbench top
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         channel;
        logic [ADDR_W-1:0]  address;
        logic               settle;
        logic [7:0]         flags;
        logic [DATA_W-1:0]  data;
        logic               last;
    } t_scan_result;

    // Results still owed by the block, oldest first
    t_scan_result       owed_results[$];

    // Shadow copy of the sequencer state and registers
    logic [DATA_W-1:0]  line_samples [LINE_SENSORS];
    logic [DATA_W-1:0]  dist_samples [2];
    logic               scan_active;
    int                 scan_pos;
    logic [7:0]         line_thr;
    logic [7:0]         dist_thr;
    int                 fail_count;

    function automatic void owe_result(t_kind kind, logic [2:0] channel,
                                       logic [ADDR_W-1:0] address, logic settle,
                                       logic [7:0] flags, logic [DATA_W-1:0] data,
                                       logic last);
        t_scan_result r;
        r.kind    = kind;
        r.channel = channel;
        r.address = address;
        r.settle  = settle;
        r.flags   = flags;
        r.data    = data;
        r.last    = last;
        owed_results.push_back(r);
    endfunction

    function automatic string result_text(t_scan_result r);
        return $sformatf("kind=%0d ch=%0d addr=%0d settle=%0b flags=%02h data=%02h last=%0b",
                         r.kind, r.channel, r.address, r.settle, r.flags, r.data, r.last);
    endfunction

    // Threshold flags: lines from FLAG_BASE upwards, then both distances
    function automatic logic [7:0] scan_flags();
        logic [7:0] f;
        int         idx;
        f = '0;
        for (int i = 0; i < FLAG_LINES; i++) begin
            idx = FLAG_BASE + i;
            if (idx < LINE_SENSORS && line_samples[idx] > line_thr)
                f[i] = 1'b1;
        end
        f[6] = dist_samples[0] > dist_thr;
        f[7] = dist_samples[1] > dist_thr;
        return f;
    endfunction

    // Works out the results of one accepted input transaction
    function automatic void predict_scan_step(t_mode mode, logic [DATA_W-1:0] smp,
                                              logic [7:0] req);
        int         first_new;
        logic [3:0] code;
        case (mode)
            MODE_START: begin
                scan_active = 1'b1;
                scan_pos    = 0;
                owe_result(KIND_CONVERT, CH_LINE, '0, 1'b1, '0, '0, 1'b1);
            end
            MODE_SAMPLE: begin
                if (scan_active) begin
                    if (scan_pos < LINE_SENSORS) begin
                        line_samples[scan_pos] = smp;
                        if (scan_pos + 1 < LINE_SENSORS) begin
                            scan_pos++;
                            owe_result(KIND_CONVERT, CH_LINE, ADDR_W'(scan_pos), 1'b1,
                                       '0, '0, 1'b1);
                        end else begin
                            scan_pos = LINE_SENSORS;
                            owe_result(KIND_CONVERT, CH_DIST0, '0, 1'b0, '0, '0, 1'b1);
                        end
                    end else if (scan_pos == LINE_SENSORS) begin
                        dist_samples[0] = smp;
                        scan_pos++;
                        owe_result(KIND_CONVERT, CH_DIST1, '0, 1'b0, '0, '0, 1'b1);
                    end else begin
                        dist_samples[1] = smp;
                        scan_active = 1'b0;
                        scan_pos    = 0;
                        owe_result(KIND_DONE, '0, '0, 1'b0, scan_flags(), '0, 1'b1);
                    end
                end
            end
            MODE_REQUEST: begin
                if (req[7:4] == 4'h0) begin
                    code      = req[3:0];
                    first_new = owed_results.size();
                    if (code == RQ_LINES || code == RQ_ALL)
                        for (int i = 0; i < LINE_SENSORS; i++)
                            owe_result(KIND_READBACK, '0, '0, 1'b0, '0, line_samples[i], 1'b0);
                    if (code == RQ_DIST0 || code == RQ_ALL)
                        owe_result(KIND_READBACK, '0, '0, 1'b0, '0, dist_samples[0], 1'b0);
                    if (code == RQ_DIST1 || code == RQ_ALL)
                        owe_result(KIND_READBACK, '0, '0, 1'b0, '0, dist_samples[1], 1'b0);
                    if (owed_results.size() > first_new)
                        owed_results[owed_results.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Watch both channels and the register port
    always @(posedge i_clk) begin
        t_scan_result seen;
        t_scan_result wanted;
        if (!i_rst_n) begin
            owed_results.delete();
            foreach (line_samples[i]) line_samples[i] = '0;
            dist_samples[0] = '0;
            dist_samples[1] = '0;
            scan_active     = 1'b0;
            scan_pos        = 0;
            line_thr        = LINE_THR_RESET;
            dist_thr        = DIST_THR_RESET;
            fail_count      = 0;
        end else begin
            // result transaction against the oldest owed result
            if (i_out_valid && i_out_ready) begin
                seen.kind    = t_kind'(i_out_kind);
                seen.channel = i_adc_channel;
                seen.address = i_line_address;
                seen.settle  = i_settle_wait;
                seen.flags   = i_flag_byte;
                seen.data    = i_data_byte;
                seen.last    = i_last;
                if (owed_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR %0t: unexpected result %s", $realtime,
                                 result_text(seen));
                end else begin
                    wanted = owed_results.pop_front();
                    if (seen !== wanted) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("ERROR %0t: result mismatch", $realtime);
                            $display("  expected %s", result_text(wanted));
                            $display("  actual   %s", result_text(seen));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_scan_step(t_mode'(i_mode), i_sample, i_request);
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_LINE_THR, 2'b00})
                    line_thr = i_pwdata[7:0];
                else if (i_paddr == {REG_DIST_THR, 2'b00})
                    dist_thr = i_pwdata[7:0];
            end
        end
        o_outstanding <= owed_results.size();
        o_fail_count  <= fail_count;
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the sensor scan sequencer: stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb;
    import sss_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 20;
    // request code that selects nothing
    localparam logic [3:0] RQ_UNUSED = 4'h1;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_mode;
    logic [DATA_W-1:0]  i_sample;
    logic [7:0]         i_request;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_out_kind;
    logic [2:0]         o_adc_channel;
    logic [ADDR_W-1:0]  o_line_address;
    logic               o_settle_wait;
    logic [7:0]         o_flag_byte;
    logic [DATA_W-1:0]  o_data_byte;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 outstanding;
    bit                 quiet;
    // long receiver hold-offs asked for by the stimulus
    int                 hold_offs_asked;

    // line samples of the directed scan, straddling the reset line threshold
    logic [7:0] line_pattern [LINE_SENSORS] =
        '{8'h00, 8'hFF, 8'h80, 8'h81, 8'h7F, 8'h81, 8'h80, 8'hFF, 8'h00, 8'h81, 8'h55};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sensor_scan_sequencer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .i_request      (i_request),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_kind     (o_out_kind),
        .o_adc_channel  (o_adc_channel),
        .o_line_address (o_line_address),
        .o_settle_wait  (o_settle_wait),
        .o_flag_byte    (o_flag_byte),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sss_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .i_request      (i_request),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_kind     (o_out_kind),
        .i_adc_channel  (o_adc_channel),
        .i_line_address (o_line_address),
        .i_settle_wait  (o_settle_wait),
        .i_flag_byte    (o_flag_byte),
        .i_data_byte    (o_data_byte),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // Offer one transaction, with an occasional idle burst first; returns once taken
    task automatic offer_item(input t_mode mode, input logic [7:0] smp,
                              input logic [7:0] req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_sample   <= smp;
        i_request  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Register write: setup cycle then access cycle
    task automatic write_threshold(input logic [0:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and wait until every owed result has been taken
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly valid readback codes, sometimes an arbitrary command byte
    function automatic logic [7:0] pick_request();
        case ($urandom_range(0, 5))
            0: return {4'h0, RQ_LINES};
            1: return {4'h0, RQ_DIST0};
            2: return {4'h0, RQ_DIST1};
            3: return {4'h0, RQ_ALL};
            default: return 8'($urandom);
        endcase
    endfunction

    // Random traffic: mostly complete scans with random samples, some
    // broken-off scans, host requests and noise
    task automatic run_random(input int n_items);
        int issued;
        issued = 0;
        while (issued < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    offer_item(MODE_START, 8'($urandom), 8'($urandom));
                    issued++;
                    for (int k = 0; k < LINE_SENSORS + 2; k++) begin
                        if ($urandom_range(0, 11) == 0) begin
                            offer_item(MODE_REQUEST, 8'($urandom), pick_request());
                            issued++;
                        end
                        if ($urandom_range(0, 24) == 0)
                            break;
                        offer_item(MODE_SAMPLE, 8'($urandom), 8'($urandom));
                        issued++;
                    end
                end
                7, 8: begin
                    offer_item(MODE_REQUEST, 8'($urandom), pick_request());
                    issued++;
                end
                default: begin
                    offer_item(t_mode'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                    issued++;
                end
            endcase
        end
    endtask

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        int hold_offs_done;
        hold_offs_done = 0;
        i_out_ready    = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_offs_done < hold_offs_asked) begin
                hold_offs_done++;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (quiet) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_START;
        i_sample        = '0;
        i_request       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        quiet           = 1'b0;
        hold_offs_asked = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset thresholds
        offer_item(MODE_REQUEST, 8'h00, {4'h0, RQ_ALL});     // store cleared by reset
        offer_item(MODE_SAMPLE, 8'hFF, 8'h00);               // sample while idle
        offer_item(MODE_RESERVED, 8'hFF, 8'hFF);
        offer_item(MODE_START, 8'h00, 8'h00);
        offer_item(MODE_SAMPLE, 8'h5A, 8'h00);
        offer_item(MODE_SAMPLE, 8'hA5, 8'h00);
        offer_item(MODE_START, 8'h00, 8'h00);                // restart mid-scan
        for (int i = 0; i < LINE_SENSORS; i++)
            offer_item(MODE_SAMPLE, line_pattern[i], 8'h00);
        offer_item(MODE_SAMPLE, 8'h20, 8'h00);               // equal to threshold
        offer_item(MODE_SAMPLE, 8'h21, 8'h00);               // just above
        offer_item(MODE_REQUEST, 8'h00, {4'h0, RQ_LINES});
        offer_item(MODE_REQUEST, 8'h00, {4'h0, RQ_DIST0});
        offer_item(MODE_REQUEST, 8'h00, {4'h0, RQ_DIST1});
        offer_item(MODE_REQUEST, 8'h00, {4'h0, RQ_ALL});
        offer_item(MODE_REQUEST, 8'h00, {4'h1, RQ_DIST0});   // non-zero high nibble
        offer_item(MODE_REQUEST, 8'h00, {4'h0, RQ_UNUSED});
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        // thresholds at the low extreme
        write_threshold(REG_LINE_THR, 8'h00);
        write_threshold(REG_DIST_THR, 8'h00);
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        // high extreme, with a long receiver hold-off to back the block up
        write_threshold(REG_LINE_THR, 8'hFF);
        write_threshold(REG_DIST_THR, 8'hFF);
        hold_offs_asked++;
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        write_threshold(REG_LINE_THR, 8'($urandom));
        write_threshold(REG_DIST_THR, 8'($urandom));
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        // final stretch at full rate
        write_threshold(REG_LINE_THR, 8'($urandom));
        write_threshold(REG_DIST_THR, 8'($urandom));
        quiet = 1'b1;
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS sensor_scan_sequencer");
        else
            $display("FAIL sensor_scan_sequencer");
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("FAIL sensor_scan_sequencer");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sss_pkg.sv
rtl/sss_ctrl.sv
rtl/sss_datapath.sv
rtl/sensor_scan_sequencer.sv
sim/sss_checker.sv
sim/tb.sv
